// File: rtl/cjs_pkg.sv
// ----------------------------------------------------------------------------
// cjs_pkg: shared types, constants and helpers for the CPU job scheduler
// Table geometry, field widths, policy and register codes, round-robin pick.
// ----------------------------------------------------------------------------
package cjs_pkg;

  localparam int MAX_JOBS = 16;
  localparam int JOB_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = JOB_W + 1;
  localparam int TIME_W   = 16;
  localparam int RUN_W    = 16;
  localparam int PRIO_W   = 8;
  localparam int SLICE_W  = 8;
  localparam int SUM_W    = 24;
  localparam int ROW_W    = TIME_W + RUN_W + PRIO_W;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_FCFS = 2'd1;
  localparam logic [1:0] POL_SJF  = 2'd2;
  localparam logic [1:0] POL_PRIO = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_PREEMPT = 2'd1;
  localparam logic [1:0] REG_SLICE   = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  typedef struct packed {
    logic               finished;
    logic [RUN_W-1:0]   rem_new;
    logic [TIME_W-1:0]  fwait;
    logic [SUM_W-1:0]   sum_new;
  } exec_res_t;

  typedef struct packed {
    logic             found;
    logic [JOB_W-1:0] idx;
  } pick_t;

  // First runnable entry at or after the start index, else the first overall.
  function automatic pick_t rr_pick(input logic [MAX_JOBS-1:0] rv,
                                    input logic [CNT_W-1:0] start);
    logic [MAX_JOBS-1:0] upper;
    pick_t               res;
    upper = '0;
    res   = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      upper[i] = rv[i] && (CNT_W'(i) >= start);
    end
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (rv[i]) begin
        res.found = 1'b1;
        res.idx   = JOB_W'(i);
      end
    end
    if (upper != '0) begin
      for (int i = MAX_JOBS - 1; i >= 0; i--) begin
        if (upper[i]) begin
          res.idx = JOB_W'(i);
        end
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/cpu_job_scheduler.sv
// ----------------------------------------------------------------------------
// cpu_job_scheduler: job table with round robin, FCFS, SJF and priority
// Memory-based job table scanned once per scheduling tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per command. in_operation OP_LOAD writes table
//           entry in_job_index; OP_TICK runs one scheduling tick.
//   out_* : one result transaction for every input transaction, in order.
//   cfg_* : register writes (policy, preempt, slice, job count); always ready,
//           write only while the block is idle.
// Sequence: a load's result is registered in the load state. A tick
//   reduces the round-robin start modulo the jobs in use, scans the table
//   RAM at one entry a cycle, then picks, reads and executes; with no job
//   in use it goes straight to read and execute. One transaction is in
//   work at a time.
// Reset: config returns to round robin, no preempt, slice 10, 16 jobs; time,
//   wait total, started and completed flags clear. Table entries are
//   undefined until loaded.
// Stall: the result sits in the output register; a finished transaction
//   holds in its last state until that register frees up.
// ----------------------------------------------------------------------------
module cpu_job_scheduler
  import cjs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [JOB_W-1:0]   in_job_index,
  input  logic [TIME_W-1:0]  in_job_arrival,
  input  logic [RUN_W-1:0]   in_job_run_time,
  input  logic [PRIO_W-1:0]  in_job_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TIME_W-1:0]  out_tick_time,
  output logic               out_idle,
  output logic [JOB_W-1:0]   out_running_job,
  output logic               out_job_finished,
  output logic [TIME_W-1:0]  out_finished_wait,
  output logic [SUM_W-1:0]   out_total_wait_sum,
  output logic               out_all_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MODS = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_PICK = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_EXEC = 3'd6;

  logic [2:0]          state_r;
  logic [1:0]          policy_r;
  logic                preempt_r;
  logic [SLICE_W-1:0]  slice_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    n_jobs;

  logic [JOB_W-1:0]    ld_idx_r;
  logic [ROW_W-1:0]    ld_row_r;

  logic [MAX_JOBS-1:0] started_r;
  logic [MAX_JOBS-1:0] completed_r;
  logic [MAX_JOBS-1:0] completed_nxt;
  logic                cur_valid_r;
  logic [JOB_W-1:0]    cur_r;
  logic [TIME_W-1:0]   now_r;
  logic [SUM_W-1:0]    wait_total_r;

  logic [CNT_W-1:0]    start_r;
  logic [CNT_W-1:0]    addr_r;
  logic                rd_v_r;
  logic [JOB_W-1:0]    rd_idx_r;
  logic [MAX_JOBS-1:0] rv_r;
  logic                best_found_r;
  logic [JOB_W-1:0]    best_idx_r;
  logic [TIME_W-1:0]   best_key_r;

  logic                out_valid_r;
  logic                out_free;
  logic                commit;
  logic                all_done_nxt;

  logic                tbl_we;
  logic [JOB_W-1:0]    tbl_raddr;
  logic [ROW_W-1:0]    tbl_rdata;
  logic [RUN_W-1:0]    rem_rdata;
  logic                rem_we;

  logic [TIME_W-1:0]   row_arr;
  logic [RUN_W-1:0]    row_run;
  logic [PRIO_W-1:0]   row_prio;
  logic [TIME_W-1:0]   scan_key;
  logic                scan_runnable;
  logic                keep;
  pick_t               rr_sel;
  exec_res_t           ex_res;

  assign n_jobs    = (count_r > CNT_W'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : count_r;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  assign row_arr  = tbl_rdata[ROW_W-1 -: TIME_W];
  assign row_run  = tbl_rdata[PRIO_W +: RUN_W];
  assign row_prio = tbl_rdata[PRIO_W-1:0];

  // Table RAM: arrival, run time and priority per entry.
  assign tbl_we    = (state_r == ST_LOAD) && out_free;
  assign tbl_raddr = (state_r == ST_SCAN) ? addr_r[JOB_W-1:0] : cur_r;

  cjs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_JOBS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ld_idx_r),
    .wdata (ld_row_r),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Remaining-time RAM; valid only once the entry's started flag is set.
  assign commit = (state_r == ST_EXEC) && out_free;
  assign rem_we = commit && cur_valid_r;

  cjs_ram #(.WIDTH(RUN_W), .DEPTH(MAX_JOBS)) u_rem (
    .clk   (clk),
    .we    (rem_we),
    .waddr (cur_r),
    .wdata (ex_res.rem_new),
    .raddr (cur_r),
    .rdata (rem_rdata)
  );

  cjs_exec u_exec (
    .started    (started_r[cur_r]),
    .rem_rd     (rem_rdata),
    .arrival    (row_arr),
    .run_time   (row_run),
    .slice      (slice_r),
    .now        (now_r),
    .wait_total (wait_total_r),
    .res        (ex_res)
  );

  // Scan key: smaller wins, priority inverted so larger priority wins.
  always_comb begin
    case (policy_r)
      POL_FCFS: scan_key = row_arr;
      POL_SJF:  scan_key = row_run;
      default:  scan_key = TIME_W'(~row_prio);
    endcase
    scan_runnable = !completed_r[rd_idx_r] && (row_arr <= now_r);
    keep   = cur_valid_r && rv_r[cur_r];
    rr_sel = rr_pick(rv_r, start_r);
  end

  // Completion flags after this commit, for all_done.
  always_comb begin
    completed_nxt = completed_r;
    if (state_r == ST_LOAD) begin
      completed_nxt[ld_idx_r] = 1'b0;
    end else if (cur_valid_r && ex_res.finished) begin
      completed_nxt[cur_r] = 1'b1;
    end
    all_done_nxt = 1'b1;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if ((CNT_W'(i) < n_jobs) && !completed_nxt[i]) begin
        all_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POL_RR;
      preempt_r    <= 1'b0;
      slice_r      <= SLICE_W'(10);
      count_r      <= CNT_W'(MAX_JOBS);
      started_r    <= '0;
      completed_r  <= '0;
      cur_valid_r  <= 1'b0;
      cur_r        <= '0;
      now_r        <= '0;
      wait_total_r <= '0;
      out_valid_r  <= 1'b0;
      rd_v_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_POLICY:  policy_r  <= cfg_data[1:0];
          REG_PREEMPT: preempt_r <= cfg_data[0];
          REG_SLICE:   slice_r   <= cfg_data;
          REG_COUNT:   count_r   <= cfg_data[CNT_W-1:0];
          default:     ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ld_idx_r <= in_job_index;
            ld_row_r <= {in_job_arrival, in_job_run_time, in_job_priority};
            if (in_operation == OP_LOAD) begin
              state_r <= ST_LOAD;
            end else if (n_jobs == '0) begin
              // No job in use: idle tick.
              cur_valid_r <= 1'b0;
              cur_r       <= '0;
              state_r     <= ST_RD;
            end else begin
              start_r <= cur_valid_r ? CNT_W'(cur_r) + CNT_W'(1) : '0;
              state_r <= ST_MODS;
            end
          end
        end

        ST_LOAD: begin
          if (out_free) begin
            started_r[ld_idx_r] <= 1'b0;
            completed_r         <= completed_nxt;
            out_valid_r         <= 1'b1;
            out_tick_time       <= now_r;
            out_idle            <= 1'b1;
            out_running_job     <= '0;
            out_job_finished    <= 1'b0;
            out_finished_wait   <= '0;
            out_total_wait_sum  <= wait_total_r;
            out_all_done        <= all_done_nxt;
            state_r             <= ST_IDLE;
          end
        end

        ST_MODS: begin
          // Reduce the round-robin start modulo the jobs in use.
          if (start_r >= n_jobs) begin
            start_r <= start_r - n_jobs;
          end else begin
            addr_r       <= '0;
            rd_v_r       <= 1'b0;
            rv_r         <= '0;
            best_found_r <= 1'b0;
            best_idx_r   <= '0;
            state_r      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Issue one read a cycle; evaluate the entry read last cycle.
          rd_v_r <= addr_r < n_jobs;
          if (addr_r < n_jobs) begin
            rd_idx_r <= addr_r[JOB_W-1:0];
            addr_r   <= addr_r + CNT_W'(1);
          end
          if (rd_v_r) begin
            rv_r[rd_idx_r] <= scan_runnable;
            if (scan_runnable && (!best_found_r || scan_key < best_key_r)) begin
              best_found_r <= 1'b1;
              best_idx_r   <= rd_idx_r;
              best_key_r   <= scan_key;
            end
            if (CNT_W'(rd_idx_r) == n_jobs - CNT_W'(1)) begin
              state_r <= ST_PICK;
            end
          end
        end

        ST_PICK: begin
          case (policy_r)
            POL_RR: begin
              cur_valid_r <= rr_sel.found;
              cur_r       <= rr_sel.found ? rr_sel.idx : '0;
            end
            POL_FCFS: begin
              if (!keep) begin
                cur_valid_r <= best_found_r;
                cur_r       <= best_idx_r;
              end
            end
            default: begin
              if (!(keep && !preempt_r)) begin
                cur_valid_r <= best_found_r;
                cur_r       <= best_idx_r;
              end
            end
          endcase
          state_r <= ST_RD;
        end

        ST_RD: begin
          state_r <= ST_EXEC;
        end

        ST_EXEC: begin
          if (commit) begin
            if (cur_valid_r) begin
              started_r[cur_r] <= 1'b1;
              completed_r      <= completed_nxt;
              if (ex_res.finished) begin
                wait_total_r <= ex_res.sum_new;
              end
            end
            now_r              <= now_r + TIME_W'(slice_r);
            out_valid_r        <= 1'b1;
            out_tick_time      <= now_r;
            out_idle           <= !cur_valid_r;
            out_running_job    <= cur_valid_r ? cur_r : '0;
            out_job_finished   <= cur_valid_r && ex_res.finished;
            out_finished_wait  <= (cur_valid_r && ex_res.finished) ? ex_res.fwait : '0;
            out_total_wait_sum <= (cur_valid_r && ex_res.finished) ? ex_res.sum_new
                                                                   : wait_total_r;
            out_all_done       <= all_done_nxt;
            state_r            <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/cjs_ram.sv
// ----------------------------------------------------------------------------
// cjs_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cjs_exec.sv
// ----------------------------------------------------------------------------
// cjs_exec: charge one time slice to the chosen job
// Remaining time, completion, wait time and saturating wait total.
// ----------------------------------------------------------------------------
module cjs_exec
  import cjs_pkg::*;
(
  input  logic               started,
  input  logic [RUN_W-1:0]   rem_rd,
  input  logic [TIME_W-1:0]  arrival,
  input  logic [RUN_W-1:0]   run_time,
  input  logic [SLICE_W-1:0] slice,
  input  logic [TIME_W-1:0]  now,
  input  logic [SUM_W-1:0]   wait_total,
  output exec_res_t          res
);

  logic [RUN_W-1:0]         rem_cur;
  logic signed [TIME_W+2:0] wait_s;
  logic [TIME_W+1:0]        wait_u;
  logic [SUM_W:0]           sum_w;

  always_comb begin
    rem_cur      = started ? rem_rd : run_time;
    res.finished = rem_cur <= RUN_W'(slice);
    res.rem_new  = res.finished ? '0 : rem_cur - RUN_W'(slice);
    wait_s = $signed({3'b0, now}) + $signed((TIME_W+3)'(slice))
           - $signed({3'b0, arrival}) - $signed({3'b0, run_time});
    wait_u = wait_s[TIME_W+2] ? '0 : wait_s[TIME_W+1:0];
    res.fwait = (wait_u[TIME_W+1:TIME_W] != 2'b0) ? '1 : wait_u[TIME_W-1:0];
    sum_w = {1'b0, wait_total} + (SUM_W+1)'(wait_u);
    res.sum_new = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
  end

endmodule
